FILE: rtl/mlcdfb_pkg.sv
`timescale 1ns / 1ps

package mlcdfb_pkg;

    // Operation codes of the input word
    typedef enum logic [2:0] {
        OP_WRITE_PIXEL = 3'd0,
        OP_READ_PIXEL  = 3'd1,
        OP_CLEAR       = 3'd2,
        OP_BEGIN_FRAME = 3'd3,
        OP_SEND_LINE   = 3'd4,
        OP_END_FRAME   = 3'd5
    } t_op;

    // Configuration register indexes
    localparam logic CFG_WRITE_COMMAND = 1'b0;
    localparam logic CFG_CLEAR_COMMAND = 1'b1;

    // Reset values of the command registers
    localparam logic [7:0] WRITE_CMD_RST = 8'h01;
    localparam logic [7:0] CLEAR_CMD_RST = 8'h04;

    // Fixed stream bytes
    localparam logic [7:0] BYTE_FILL    = 8'hFF;
    localparam logic [7:0] BYTE_TRAILER = 8'h00;

    // Width of y * width + x for 8-bit rows and 9-bit columns
    localparam int LIN_W = 17;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_PIX_ANS,
        ST_CMD,
        ST_TRL,
        ST_SWEEP,
        ST_LINE_HDR,
        ST_LINE_RD,
        ST_LINE_DAT,
        ST_LINE_TRL
    } t_state;

endpackage

FILE: rtl/mlcdfb_ram.sv
`timescale 1ns / 1ps

module mlcdfb_ram #(
    parameter int DEPTH = 12000,
    parameter int AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // single port, registered read that holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/memory_lcd_framebuffer_serializer.sv
`timescale 1ns / 1ps

// 1-bit framebuffer for a memory LCD with a byte serializer for the panel.
// Input channel (i_valid/o_ready) takes one command word: write pixel, read
// pixel, clear, begin frame, send line or end frame. Output channel
// (o_valid/i_ready) returns panel bytes and pixel read answers; o_last marks
// the final word caused by a command. Commands are handled one at a time.
// Steps per command, from acceptance until the next can be accepted:
//   write pixel: address multiply, read, modify-write
//   read pixel: address multiply, read, answer load
//   begin/end frame: address, then the command or trailer byte
//   send line: address, header byte, line bytes, trailer byte
//   clear: address, command byte, trailer byte; then the store is filled with
//   ones one byte per cycle through the single memory port (12000 bytes at the
//   default size); no command is taken during that pass.
// Each line byte is one memory read followed by one output load.
// One output register holds a finished word, so a new command is taken while
// the previous word waits; a stalled receiver simply stretches each step.
// Reset restores the command registers and empties the output register; the
// store itself is not cleared and holds nothing defined until written.
// Configuration writes (i_cfg_we) take effect at once and belong to idle time.
module memory_lcd_framebuffer_serializer
    import mlcdfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = 400,
    parameter int PANEL_HEIGHT = 240
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_operation,
    input  logic [8:0] i_x_coord,
    input  logic [7:0] i_y_coord,
    input  logic       i_pixel_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_is_stream_byte,
    output logic [7:0] o_stream_byte,
    output logic       o_pixel_bit,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
    localparam int LINE_BYTES  = PANEL_WIDTH / 8;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CW          = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

    t_state            r_state, n_state;
    logic [7:0]        r_write_cmd, r_clear_cmd;
    logic [2:0]        r_op;
    logic [8:0]        r_x;
    logic [7:0]        r_y;
    logic              r_val;
    logic              r_inside, n_inside;
    logic [AW-1:0]     r_addr, n_addr;
    logic [CW-1:0]     r_cnt, n_cnt;

    logic              r_o_valid;
    logic              r_o_is_stream;
    logic [7:0]        r_o_byte;
    logic              r_o_bit;
    logic              r_o_last;

    logic              out_free;
    logic              load;
    logic              ld_is_stream;
    logic [7:0]        ld_byte;
    logic              ld_bit;
    logic              ld_last;

    logic              mem_we, mem_re;
    logic [7:0]        mem_wdata, mem_rdata;
    logic [7:0]        pix_mask;
    logic [LIN_W-1:0]  lin;
    logic [LIN_W-1:0]  lin_shift;

    assign out_free = !r_o_valid || i_ready;
    assign o_ready  = (r_state == ST_IDLE);
    assign pix_mask = 8'(1) << r_x[2:0];

    // address arithmetic: byte index of the pixel or of the line start
    always_comb begin
        if (r_op == OP_SEND_LINE) begin
            lin = LIN_W'(r_y) * LIN_W'(LINE_BYTES);
        end else begin
            lin = LIN_W'(r_y) * LIN_W'(PANEL_WIDTH) + LIN_W'(r_x);
        end
        lin_shift = (r_op == OP_SEND_LINE) ? lin : (lin >> 3);
    end

    // next state, memory control and output loads
    always_comb begin
        n_state      = r_state;
        n_inside     = r_inside;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        load         = 1'b0;
        ld_is_stream = 1'b1;
        ld_byte      = BYTE_TRAILER;
        ld_bit       = 1'b0;
        ld_last      = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wdata    = BYTE_FILL;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_inside = (r_x < 9'(PANEL_WIDTH)) && (r_y < 8'(PANEL_HEIGHT));
                n_addr   = lin_shift[AW-1:0];
                n_cnt    = '0;
                if (r_op == OP_WRITE_PIXEL) begin
                    n_state = n_inside ? ST_PIX_RD : ST_IDLE;
                end else if (r_op == OP_READ_PIXEL) begin
                    n_state = n_inside ? ST_PIX_RD : ST_PIX_ANS;
                end else if (r_op == OP_CLEAR || r_op == OP_BEGIN_FRAME) begin
                    n_state = ST_CMD;
                end else if (r_op == OP_SEND_LINE) begin
                    n_state = (r_y < 8'(PANEL_HEIGHT)) ? ST_LINE_HDR : ST_IDLE;
                end else if (r_op == OP_END_FRAME) begin
                    n_state = ST_TRL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PIX_RD: begin
                mem_re  = 1'b1;
                n_state = (r_op == OP_WRITE_PIXEL) ? ST_PIX_WR : ST_PIX_ANS;
            end
            ST_PIX_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_val ? (mem_rdata | pix_mask) : (mem_rdata & ~pix_mask);
                n_state   = ST_IDLE;
            end
            ST_PIX_ANS: begin
                if (out_free) begin
                    load         = 1'b1;
                    ld_is_stream = 1'b0;
                    ld_byte      = 8'h00;
                    ld_bit       = r_inside && mem_rdata[r_x[2:0]];
                    ld_last      = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_CMD: begin
                if (out_free) begin
                    load = 1'b1;
                    if (r_op == OP_CLEAR) begin
                        ld_byte = r_clear_cmd;
                        n_state = ST_TRL;
                    end else begin
                        ld_byte = r_write_cmd;
                        ld_last = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TRL: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_last = 1'b1;
                    n_addr  = '0;
                    n_state = (r_op == OP_CLEAR) ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP: begin
                // fill one byte with ones per cycle
                mem_we = 1'b1;
                if (r_addr == AW'(STORE_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_LINE_HDR: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = r_y + 8'd1;
                    n_state = ST_LINE_RD;
                end
            end
            ST_LINE_RD: begin
                mem_re  = 1'b1;
                n_state = ST_LINE_DAT;
            end
            ST_LINE_DAT: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = mem_rdata;
                    if (r_cnt == CW'(LINE_BYTES - 1)) begin
                        n_state = ST_LINE_TRL;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_addr  = r_addr + 1'b1;
                        n_state = ST_LINE_RD;
                    end
                end
            end
            ST_LINE_TRL: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // command registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_cmd <= WRITE_CMD_RST;
            r_clear_cmd <= CLEAR_CMD_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_WRITE_COMMAND) begin
                r_write_cmd <= i_cfg_data;
            end else begin
                r_clear_cmd <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_op  <= i_operation;
            r_x   <= i_x_coord;
            r_y   <= i_y_coord;
            r_val <= i_pixel_value;
        end
        r_inside <= n_inside;
        r_addr   <= n_addr;
        r_cnt    <= n_cnt;
        if (load) begin
            r_o_is_stream <= ld_is_stream;
            r_o_byte      <= ld_byte;
            r_o_bit       <= ld_bit;
            r_o_last      <= ld_last;
        end
    end

    mlcdfb_ram #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (r_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_valid          = r_o_valid;
    assign o_is_stream_byte = r_o_is_stream;
    assign o_stream_byte    = r_o_byte;
    assign o_pixel_bit      = r_o_bit;
    assign o_last           = r_o_last;

endmodule

FILE: tb/tb_memory_lcd_framebuffer_serializer.sv
`timescale 1ns / 1ps

module tb_memory_lcd_framebuffer_serializer;
    import mlcdfb_pkg::*;

    localparam int PANEL_W     = 400;
    localparam int PANEL_H     = 240;
    localparam int LINE_BYTES  = PANEL_W / 8;
    localparam int STORE_BYTES = (PANEL_W * PANEL_H + 7) / 8;
    // Quiet time before a register write: covers the fill pass of a clear
    localparam int SETTLE      = STORE_BYTES + 64;
    localparam int QUIET_LIMIT = 40000;
    localparam int HOLD_CYCLES = 300;

    // Codes the block ignores
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [8:0] x;
        logic [7:0] y;
        logic       v;
    } t_cmd;

    typedef struct packed {
        logic       is_stream;
        logic [7:0] data;
        logic       pix;
        logic       last;
    } t_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [2:0] i_operation;
    logic [8:0] i_x_coord;
    logic [7:0] i_y_coord;
    logic       i_pixel_value;
    logic       o_valid;
    logic       i_ready;
    logic       o_is_stream_byte;
    logic [7:0] o_stream_byte;
    logic       o_pixel_bit;
    logic       o_last;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    // Shadow image and command registers
    logic [7:0] shadow_fb [STORE_BYTES];
    logic [7:0] frame_cmd;
    logic [7:0] wipe_cmd;

    t_cmd  cmd_queue [$];
    t_word due_words [$];

    logic  cmd_taken;
    bit    failed;
    bit    calm;
    bit    hold_req;
    int    hold_left;
    int    send_gap;
    int    send_odds;
    int    take_gap;
    int    take_odds;
    int    quiet_cycles;
    t_cmd  cur_cmd;

    memory_lcd_framebuffer_serializer #(
        .PANEL_WIDTH (PANEL_W),
        .PANEL_HEIGHT(PANEL_H)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_x_coord       (i_x_coord),
        .i_y_coord       (i_y_coord),
        .i_pixel_value   (i_pixel_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_is_stream_byte(o_is_stream_byte),
        .o_stream_byte   (o_stream_byte),
        .o_pixel_bit     (o_pixel_bit),
        .o_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic push_word(input logic s, input logic [7:0] d, input logic p,
                             input logic l);
        due_words.push_back('{is_stream: s, data: d, pix: p, last: l});
    endtask

    // Expected panel words and image update for one accepted command word
    task automatic serialize_command(input t_cmd c);
        logic       in_panel;
        int         idx;
        logic [7:0] mask;
        in_panel = (int'(c.x) < PANEL_W) && (int'(c.y) < PANEL_H);
        idx      = (int'(c.y) * PANEL_W + int'(c.x)) / 8;
        mask     = 8'h01 << c.x[2:0];
        case (c.op)
            OP_WRITE_PIXEL: begin
                if (in_panel)
                    shadow_fb[idx] = c.v ? (shadow_fb[idx] | mask) : (shadow_fb[idx] & ~mask);
            end
            OP_READ_PIXEL: begin
                push_word(1'b0, 8'h00, in_panel ? |(shadow_fb[idx] & mask) : 1'b0, 1'b1);
            end
            OP_CLEAR: begin
                foreach (shadow_fb[i]) shadow_fb[i] = BYTE_FILL;
                push_word(1'b1, wipe_cmd, 1'b0, 1'b0);
                push_word(1'b1, BYTE_TRAILER, 1'b0, 1'b1);
            end
            OP_BEGIN_FRAME: begin
                push_word(1'b1, frame_cmd, 1'b0, 1'b1);
            end
            OP_SEND_LINE: begin
                if (int'(c.y) < PANEL_H) begin
                    push_word(1'b1, c.y + 8'd1, 1'b0, 1'b0);
                    for (int i = 0; i < LINE_BYTES; i++)
                        push_word(1'b1, shadow_fb[int'(c.y) * LINE_BYTES + i], 1'b0, 1'b0);
                    push_word(1'b1, BYTE_TRAILER, 1'b0, 1'b1);
                end
            end
            OP_END_FRAME: begin
                push_word(1'b1, BYTE_TRAILER, 1'b0, 1'b1);
            end
            default: begin
            end
        endcase
    endtask

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            failed = 1'b1;
        end
    endfunction

    // Predict on accepted commands, check accepted words
    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= i_valid && o_ready;
            if (i_valid && o_ready)
                serialize_command('{op: i_operation, x: i_x_coord, y: i_y_coord,
                                    v: i_pixel_value});
            if (o_valid && i_ready) begin
                if (due_words.size() == 0) begin
                    $display("%0t: word with none expected, expected nothing, actual %h/%h/%h/%h",
                             $time, o_is_stream_byte, o_stream_byte, o_pixel_bit, o_last);
                    failed = 1'b1;
                end else begin
                    want = due_words.pop_front();
                    check_field("is_stream_byte", 8'(want.is_stream), 8'(o_is_stream_byte));
                    check_field("stream_byte", want.data, o_stream_byte);
                    check_field("pixel_bit", 8'(want.pix), 8'(o_pixel_bit));
                    check_field("last", 8'(want.last), 8'(o_last));
                end
            end
        end
    end

    // Command driver: holds the word until taken, random gaps between words
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || cmd_taken) begin
            if ($urandom_range(0, 31) == 0) send_odds = $urandom_range(0, 2) * 20;
            if (!calm && send_gap == 0 && $urandom_range(0, 99) < send_odds)
                send_gap = $urandom_range(1, 4);
            if (send_gap > 0 || cmd_queue.size() == 0) begin
                if (send_gap > 0) send_gap--;
                i_valid <= 1'b0;
            end else begin
                cur_cmd = cmd_queue.pop_front();
                i_valid       <= 1'b1;
                i_operation   <= cur_cmd.op;
                i_x_coord     <= cur_cmd.x;
                i_y_coord     <= cur_cmd.y;
                i_pixel_value <= cur_cmd.v;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 31) == 0) take_odds = $urandom_range(0, 2) * 20;
            if (!calm && take_gap == 0 && $urandom_range(0, 99) < take_odds)
                take_gap = $urandom_range(1, 4);
            if (take_gap > 0) begin
                take_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_cmd(input logic [2:0] op, input logic [8:0] x, input logic [7:0] y,
                           input logic v);
        cmd_queue.push_back('{op: op, x: x, y: y, v: v});
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WRITE_COMMAND) frame_cmd = val;
        else wipe_cmd = val;
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || i_valid || due_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Rows cluster on the first lines so line output shows the pixel writes
    function automatic logic [7:0] pick_row();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) return 8'($urandom_range(0, 5));
        if (r == 8) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'(PANEL_H - 1);
            2: return 8'(PANEL_H);
            default: return 8'd255;
        endcase
    endfunction

    function automatic logic [8:0] pick_col();
        if ($urandom_range(0, 9) < 7) return 9'($urandom_range(0, 511));
        case ($urandom_range(0, 5))
            0: return 9'd0;
            1: return 9'd7;
            2: return 9'd8;
            3: return 9'(PANEL_W - 1);
            4: return 9'(PANEL_W);
            default: return 9'($urandom_range(0, 15));
        endcase
    endfunction

    // Random traffic: mostly frame updates and pixel bursts, some noise
    task automatic queue_random(input int n, input bit with_clear);
        int         done;
        int         sel;
        logic [7:0] row;
        logic [8:0] col;
        logic [2:0] op;
        bit         broken;
        done = 0;
        while (done < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                broken = ($urandom_range(0, 6) == 0);
                if (!(broken && $urandom_range(0, 1))) begin
                    add_cmd(OP_BEGIN_FRAME, 9'($urandom), 8'($urandom), 1'($urandom));
                    done++;
                end
                repeat ($urandom_range(1, 3)) begin
                    row = pick_row();
                    add_cmd(OP_SEND_LINE, 9'($urandom), row, 1'($urandom));
                    if (int'(row) < PANEL_H) done++;
                end
                if (!broken || $urandom_range(0, 1)) begin
                    add_cmd(OP_END_FRAME, 9'($urandom), 8'($urandom), 1'($urandom));
                    done++;
                end
            end else if (sel < 80) begin
                repeat ($urandom_range(1, 6)) begin
                    op  = ($urandom_range(0, 99) < 65) ? OP_WRITE_PIXEL : OP_READ_PIXEL;
                    col = pick_col();
                    row = pick_row();
                    add_cmd(op, col, row, 1'($urandom));
                    if (op == OP_READ_PIXEL || (int'(col) < PANEL_W && int'(row) < PANEL_H))
                        done++;
                end
            end else if (sel < 83 && with_clear) begin
                add_cmd(OP_CLEAR, 9'($urandom), 8'($urandom), 1'($urandom));
                done++;
            end else if (sel < 88) begin
                op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
                add_cmd(op, 9'($urandom), 8'($urandom), 1'($urandom));
            end else begin
                op = $urandom_range(0, 1) ? OP_BEGIN_FRAME : OP_END_FRAME;
                add_cmd(op, 9'($urandom), 8'($urandom), 1'($urandom));
                done++;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_operation   = OP_WRITE_PIXEL;
        i_x_coord     = '0;
        i_y_coord     = '0;
        i_pixel_value = 1'b0;
        i_ready       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_WRITE_COMMAND;
        i_cfg_data    = '0;
        frame_cmd     = WRITE_CMD_RST;
        wipe_cmd      = CLEAR_CMD_RST;
        failed        = 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        send_gap      = 0;
        send_odds     = 20;
        take_gap      = 0;
        take_odds     = 20;
        quiet_cycles  = 0;
        foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset command values; nothing reads the image
        // until the clear has filled it
        add_cmd(OP_BEGIN_FRAME, 9'd0, 8'd0, 1'b0);
        add_cmd(OP_END_FRAME, 9'd511, 8'd255, 1'b1);
        add_cmd(OP_SPARE_6, 9'd511, 8'd255, 1'b1);
        add_cmd(OP_SPARE_7, 9'd0, 8'd0, 1'b0);
        add_cmd(OP_READ_PIXEL, 9'(PANEL_W), 8'd0, 1'b0);
        add_cmd(OP_READ_PIXEL, 9'd0, 8'(PANEL_H), 1'b0);
        add_cmd(OP_READ_PIXEL, 9'd511, 8'd255, 1'b1);
        add_cmd(OP_WRITE_PIXEL, 9'd511, 8'd255, 1'b1);
        add_cmd(OP_WRITE_PIXEL, 9'(PANEL_W), 8'd10, 1'b1);
        add_cmd(OP_SEND_LINE, 9'd0, 8'(PANEL_H), 1'b0);
        add_cmd(OP_SEND_LINE, 9'd511, 8'd255, 1'b1);
        add_cmd(OP_CLEAR, 9'd0, 8'd0, 1'b0);
        add_cmd(OP_READ_PIXEL, 9'd0, 8'd0, 1'b0);
        add_cmd(OP_WRITE_PIXEL, 9'd0, 8'd0, 1'b0);
        add_cmd(OP_WRITE_PIXEL, 9'(PANEL_W - 1), 8'(PANEL_H - 1), 1'b0);
        add_cmd(OP_WRITE_PIXEL, 9'd7, 8'd0, 1'b0);
        add_cmd(OP_WRITE_PIXEL, 9'd8, 8'd0, 1'b0);
        add_cmd(OP_READ_PIXEL, 9'd0, 8'd0, 1'b1);
        add_cmd(OP_READ_PIXEL, 9'(PANEL_W - 1), 8'(PANEL_H - 1), 1'b0);
        add_cmd(OP_READ_PIXEL, 9'(PANEL_W - 2), 8'(PANEL_H - 1), 1'b0);
        add_cmd(OP_BEGIN_FRAME, 9'd0, 8'd0, 1'b0);
        add_cmd(OP_SEND_LINE, 9'd0, 8'd0, 1'b0);
        add_cmd(OP_SEND_LINE, 9'd0, 8'(PANEL_H - 1), 1'b0);
        add_cmd(OP_END_FRAME, 9'd0, 8'd0, 1'b0);
        add_cmd(OP_WRITE_PIXEL, 9'd0, 8'd0, 1'b1);
        add_cmd(OP_READ_PIXEL, 9'd0, 8'd0, 1'b0);
        wait_idle();

        // Low/high command extremes, long receiver hold-off at the start
        write_reg(CFG_WRITE_COMMAND, 8'h00);
        write_reg(CFG_CLEAR_COMMAND, 8'hFF);
        hold_req = 1'b1;
        queue_random(95, 1'b1);
        wait_idle();

        write_reg(CFG_WRITE_COMMAND, 8'hFF);
        write_reg(CFG_CLEAR_COMMAND, 8'h00);
        queue_random(95, 1'b1);
        wait_idle();

        // Random commands; the final stretch runs without any idling
        write_reg(CFG_WRITE_COMMAND, 8'($urandom));
        write_reg(CFG_CLEAR_COMMAND, 8'($urandom));
        queue_random(60, 1'b1);
        while (cmd_queue.size() != 0) @(negedge i_clk);
        calm = 1'b1;
        queue_random(45, 1'b0);
        wait_idle();

        if (!failed)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
